// ----- hdl/ulmp_pkg.sv -----
// ----------------------------------------------------------------------------
// ulmp_pkg
// Shared constants, register codes and link types of the level median pump.
// ----------------------------------------------------------------------------
package ulmp_pkg;

  localparam int PINGS_PER_ROUND = 5;
  localparam int TICKS_PER_CM    = 58;

  localparam int TICKS_W    = 16;
  localparam int CM_W       = 6;
  localparam int PCT_W      = 7;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam int KEPT_W = $clog2(PINGS_PER_ROUND + 1);
  localparam int SLOT_W = (PINGS_PER_ROUND > 1) ? $clog2(PINGS_PER_ROUND) : 1;

  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = TICKS_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_MULT =
    RECIP_W'((2 ** RECIP_SHIFT + TICKS_PER_CM - 1) / TICKS_PER_CM);

  localparam logic [PCT_W-1:0] LEVEL_MAX = 7'd100;

  localparam logic [CM_W-1:0]  FULL_CM_RST        = 6'd10;
  localparam logic [CM_W-1:0]  EMPTY_CM_RST       = 6'd30;
  localparam logic [PCT_W-1:0] PERCENT_PER_CM_RST = 7'd5;
  localparam logic [CM_W-1:0]  MAX_VALID_CM_RST   = 6'd50;
  localparam logic [CM_W-1:0]  FALLBACK_CM_RST    = 6'd40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_CM        = 3'd0,
    CFG_EMPTY_CM       = 3'd1,
    CFG_PERCENT_PER_CM = 3'd2,
    CFG_MAX_VALID_CM   = 3'd3,
    CFG_FALLBACK_CM    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic            item;
    logic            first;
    logic            keep;
    logic [CM_W-1:0] value;
  } ins_t;

  typedef struct packed {
    logic            gt;
    logic            occ;
    logic [CM_W-1:0] value;
  } link_t;

  typedef struct packed {
    logic [KEPT_W-1:0] kept;
    logic [CM_W-1:0]   median;
  } chain_stat_t;

endpackage

// ----- hdl/ulmp_cell.sv -----
// ----------------------------------------------------------------------------
// ulmp_cell
// One slot of the sorted reading chain: keeps or shifts in a reading.
// ----------------------------------------------------------------------------
module ulmp_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  ulmp_pkg::ins_t                      ins,
  input  ulmp_pkg::link_t                     left,
  output ulmp_pkg::link_t                     right,
  output logic                                held_occ,
  output logic [ulmp_pkg::CM_W-1:0]           held_value
);

  logic                      occ;
  logic                      occ_live;
  logic                      occ_next;
  logic                      gt;
  logic [ulmp_pkg::CM_W-1:0] value;
  logic [ulmp_pkg::CM_W-1:0] value_next;

  always_comb begin
    occ_live   = occ && !ins.first;
    gt         = !occ_live || (value > ins.value);
    occ_next   = occ_live || (ins.keep && left.occ);
    value_next = value;
    if (ins.keep && gt) begin
      value_next = left.gt ? left.value : ins.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (en && ins.item) begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && ins.item) begin
      value <= value_next;
    end
  end

  assign right      = '{gt: gt, occ: occ_live, value: value};
  assign held_occ   = occ;
  assign held_value = value;

endmodule

// ----- hdl/ulmp_chain.sv -----
// ----------------------------------------------------------------------------
// ulmp_chain
// Row of sorting cells with the kept count and upper median taken off it.
// ----------------------------------------------------------------------------
module ulmp_chain (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  ulmp_pkg::ins_t        ins,
  output ulmp_pkg::chain_stat_t stat
);

  ulmp_pkg::link_t                 links [ulmp_pkg::PINGS_PER_ROUND+1];
  logic                            occ   [ulmp_pkg::PINGS_PER_ROUND];
  logic [ulmp_pkg::CM_W-1:0]       vals  [ulmp_pkg::PINGS_PER_ROUND];
  logic [ulmp_pkg::KEPT_W-1:0]     kept;
  logic [ulmp_pkg::KEPT_W-1:0]     mid;
  logic [ulmp_pkg::CM_W-1:0]       median;

  assign links[0] = '{gt: 1'b0, occ: 1'b1, value: '0};

  for (genvar i = 0; i < ulmp_pkg::PINGS_PER_ROUND; i++) begin : g_cell
    ulmp_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .ins        (ins),
      .left       (links[i]),
      .right      (links[i+1]),
      .held_occ   (occ[i]),
      .held_value (vals[i])
    );
  end

  always_comb begin
    kept = '0;
    for (int i = 0; i < ulmp_pkg::PINGS_PER_ROUND; i++) begin
      kept = kept + ulmp_pkg::KEPT_W'(occ[i]);
    end
    mid    = kept >> 1;
    median = '0;
    for (int i = 0; i < ulmp_pkg::PINGS_PER_ROUND; i++) begin
      if (ulmp_pkg::KEPT_W'(i) == mid) begin
        median = vals[i];
      end
    end
  end

  assign stat = '{kept: kept, median: median};

endmodule

// ----- hdl/ulmp_level.sv -----
// ----------------------------------------------------------------------------
// ulmp_level
// Registered distance to fill level mapping, saturated at full.
// ----------------------------------------------------------------------------
module ulmp_level (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ulmp_pkg::CM_W-1:0]  distance,
  input  logic [ulmp_pkg::CM_W-1:0]  full_cm,
  input  logic [ulmp_pkg::CM_W-1:0]  empty_cm,
  input  logic [ulmp_pkg::PCT_W-1:0] percent_per_cm,
  output logic [ulmp_pkg::PCT_W-1:0] level
);

  logic [ulmp_pkg::CM_W-1:0]                diff;
  logic [ulmp_pkg::CM_W+ulmp_pkg::PCT_W-1:0] prod;
  logic [ulmp_pkg::PCT_W-1:0]               level_next;

  always_comb begin
    diff = empty_cm - distance;
    prod = (ulmp_pkg::CM_W + ulmp_pkg::PCT_W)'(diff) *
           (ulmp_pkg::CM_W + ulmp_pkg::PCT_W)'(percent_per_cm);
    if (distance >= empty_cm) begin
      level_next = '0;
    end else if (distance <= full_cm) begin
      level_next = ulmp_pkg::LEVEL_MAX;
    end else if (prod > (ulmp_pkg::CM_W + ulmp_pkg::PCT_W)'(ulmp_pkg::LEVEL_MAX)) begin
      level_next = ulmp_pkg::LEVEL_MAX;
    end else begin
      level_next = prod[ulmp_pkg::PCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level <= level_next;
    end
  end

endmodule

// ----- hdl/ultrasonic_level_median_pump.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_level_median_pump
// Ping to centimeter conversion, sorted median per round and pump control.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    echo_seen, echo_ticks
//   out      out_valid / out_stall  distance_cm, level_percent, pump_on,
//                                   display_update, valid_count
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One ping per cycle while in_stall is low; a round's result is valid once its last
// ping has passed the capture, conversion, chain, median, level and output registers.
// The whole pipeline and the cell chain advance together; they hold only
// while a result waits in the output register and out_stall is high.
// Reset is synchronous and clears the round, the cells and the last result.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module ultrasonic_level_median_pump (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            echo_seen,
  input  logic [ulmp_pkg::TICKS_W-1:0]    echo_ticks,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ulmp_pkg::CM_W-1:0]       distance_cm,
  output logic [ulmp_pkg::PCT_W-1:0]      level_percent,
  output logic                            pump_on,
  output logic                            display_update,
  output logic [ulmp_pkg::CNT_W-1:0]      valid_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ulmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ulmp_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [ulmp_pkg::CM_W-1:0]  full_cm;
  logic [ulmp_pkg::CM_W-1:0]  empty_cm;
  logic [ulmp_pkg::PCT_W-1:0] percent_per_cm;
  logic [ulmp_pkg::CM_W-1:0]  max_valid_cm;
  logic [ulmp_pkg::CM_W-1:0]  fallback_cm;

  logic                          en;
  logic [ulmp_pkg::SLOT_W-1:0]   slot;

  logic                          v1, seen1, first1, last1;
  logic [ulmp_pkg::TICKS_W-1:0]  ticks1;
  logic [ulmp_pkg::PROD_W-1:0]   prod1;
  logic [ulmp_pkg::TICKS_W-1:0]  cm1;
  logic                          keep1;

  logic                          v2, keep2, first2, last2;
  logic [ulmp_pkg::CM_W-1:0]     cm2;
  ulmp_pkg::ins_t                ins;

  logic                          v3;
  ulmp_pkg::chain_stat_t         stat;
  logic [ulmp_pkg::CM_W-1:0]     d3;

  logic                          v4;
  logic [ulmp_pkg::CM_W-1:0]     d4;
  logic [ulmp_pkg::CNT_W-1:0]    cnt4;

  logic                          v5;
  logic [ulmp_pkg::CM_W-1:0]     d5;
  logic [ulmp_pkg::CNT_W-1:0]    cnt5;
  logic [ulmp_pkg::PCT_W-1:0]    lvl5;
  logic                          pump5;
  logic                          upd5;

  logic                          have_prev;
  logic [ulmp_pkg::CM_W-1:0]     prev_distance;
  logic                          prev_pump;

  assign cfg_ready = 1'b1;
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_cm        <= ulmp_pkg::FULL_CM_RST;
      empty_cm       <= ulmp_pkg::EMPTY_CM_RST;
      percent_per_cm <= ulmp_pkg::PERCENT_PER_CM_RST;
      max_valid_cm   <= ulmp_pkg::MAX_VALID_CM_RST;
      fallback_cm    <= ulmp_pkg::FALLBACK_CM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ulmp_pkg::CFG_FULL_CM:        full_cm        <= cfg_data[ulmp_pkg::CM_W-1:0];
        ulmp_pkg::CFG_EMPTY_CM:       empty_cm       <= cfg_data[ulmp_pkg::CM_W-1:0];
        ulmp_pkg::CFG_PERCENT_PER_CM: percent_per_cm <= cfg_data[ulmp_pkg::PCT_W-1:0];
        ulmp_pkg::CFG_MAX_VALID_CM:   max_valid_cm   <= cfg_data[ulmp_pkg::CM_W-1:0];
        ulmp_pkg::CFG_FALLBACK_CM:    fallback_cm    <= cfg_data[ulmp_pkg::CM_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the ping and tag its place in the round.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      v1   <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      if (in_valid) begin
        if (slot == ulmp_pkg::SLOT_W'(ulmp_pkg::PINGS_PER_ROUND - 1)) begin
          slot <= '0;
        end else begin
          slot <= slot + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      seen1  <= echo_seen;
      ticks1 <= echo_ticks;
      first1 <= (slot == '0);
      last1  <= (slot == ulmp_pkg::SLOT_W'(ulmp_pkg::PINGS_PER_ROUND - 1));
    end
  end

  // Divide by ticks per cm through the reciprocal, then range check.
  always_comb begin
    prod1 = ulmp_pkg::PROD_W'(ticks1) * ulmp_pkg::PROD_W'(ulmp_pkg::RECIP_MULT);
    cm1   = prod1[ulmp_pkg::RECIP_SHIFT +: ulmp_pkg::TICKS_W];
    keep1 = seen1 && (cm1 != '0) && (cm1 <= ulmp_pkg::TICKS_W'(max_valid_cm));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      keep2  <= keep1;
      cm2    <= cm1[ulmp_pkg::CM_W-1:0];
      first2 <= first1;
      last2  <= last1;
    end
  end

  assign ins = '{item: v2, first: first2, keep: keep2, value: cm2};

  ulmp_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .ins  (ins),
    .stat (stat)
  );

  assign d3 = (stat.kept == '0) ? fallback_cm : stat.median;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v3 <= v2 && last2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d4   <= d3;
      cnt4 <= ulmp_pkg::CNT_W'(stat.kept);
      d5   <= d4;
      cnt5 <= cnt4;
    end
  end

  ulmp_level u_level (
    .clk            (clk),
    .en             (en),
    .distance       (d4),
    .full_cm        (full_cm),
    .empty_cm       (empty_cm),
    .percent_per_cm (percent_per_cm),
    .level          (lvl5)
  );

  assign pump5 = (lvl5 < ulmp_pkg::LEVEL_MAX);
  assign upd5  = !have_prev || (d5 != prev_distance) || (pump5 != prev_pump);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      have_prev     <= 1'b0;
      prev_distance <= '0;
      prev_pump     <= 1'b0;
    end else if (en) begin
      out_valid <= v5;
      if (v5) begin
        have_prev     <= 1'b1;
        prev_distance <= d5;
        prev_pump     <= pump5;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && v5) begin
      distance_cm    <= d5;
      level_percent  <= lvl5;
      pump_on        <= pump5;
      display_update <= upd5;
      valid_count    <= cnt5;
    end
  end

endmodule

// ----- hdl/ulmp_checker.sv -----
// ----------------------------------------------------------------------------
// ulmp_checker
// Port-level checks on the result stream of the level median pump.
// ----------------------------------------------------------------------------
module ulmp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [ulmp_pkg::CM_W-1:0]       distance_cm,
  input logic [ulmp_pkg::PCT_W-1:0]      level_percent,
  input logic                            pump_on,
  input logic                            display_update,
  input logic [ulmp_pkg::CNT_W-1:0]      valid_count
);

  logic                      seen_any;
  logic [ulmp_pkg::CM_W-1:0] last_dist;
  logic                      last_pump;
  logic                      out_take;

  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_any  <= 1'b0;
      last_dist <= '0;
      last_pump <= 1'b0;
    end else if (out_take) begin
      seen_any  <= 1'b1;
      last_dist <= distance_cm;
      last_pump <= pump_on;
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance_cm) &&
                               $stable(level_percent) && $stable(display_update))
    else $error("stalled result changed");

  a_pump_matches_level: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level_percent <= ulmp_pkg::LEVEL_MAX) &&
                  (pump_on == (level_percent < ulmp_pkg::LEVEL_MAX)))
    else $error("pump state disagrees with level");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (valid_count <= ulmp_pkg::CNT_W'(ulmp_pkg::PINGS_PER_ROUND)))
    else $error("kept count beyond round size");

  a_update_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> display_update ==
                  (!seen_any || (distance_cm != last_dist) || (pump_on != last_pump)))
    else $error("display update flag wrong");

endmodule

bind ultrasonic_level_median_pump ulmp_checker u_ulmp_checker (.*);
